### hdl/nbts_pkg.sv
`timescale 1ns / 1ps
package nbts_pkg;

  // Fixed field widths of the channels
  localparam int CW            = 16;  // coordinate and bound width
  localparam int IDX_BITS      = 13;  // entry index width
  localparam int ID_BITS       = 16;  // result id width
  localparam int FIT_BITS      = 35;  // fitness width
  localparam int CNT_BITS      = 14;  // entry count register width
  localparam int SAMPLE_FIELDS = 6;   // coordinates carried by a query

  // Parameter defaults
  localparam int DEF_MAX_ENTRIES = 8192;
  localparam int DEF_NUM_AXES    = 6;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  // Tag that travels with each table read through the fitness pipeline
  typedef struct packed {
    logic                valid;
    logic                first;  // first slot of an entry
    logic                last;   // offset slot, closes the entry
    logic [IDX_BITS-1:0] entry;
  } scan_tag_t;

endpackage

### hdl/nearest_box_table_search.sv
`timescale 1ns / 1ps
// Nearest box table search.
// Input channel (in_valid/in_ready) carries write and query items. A write
// (in_action low) stores one axis range, or the offset when in_axis_index
// equals the axis count, of one entry together with its id; it gives no
// result. A query (in_action high) scans entries 0 .. cfg count-1 (count
// capped at MAX_ENTRIES) and gives one result on the out_valid/out_ready
// channel. Each entry passes through one shared squarer one slot a cycle
// (one slot per axis plus the offset slot). in_ready is low for the whole
// scan. An empty table skips the scan and gives a result from the done
// state with out_empty_error set.
// The finished result sits in an output register; the block takes the next
// item while it waits. If the receiver still stalls when the next query
// ends, the block holds in its done state until the transfer frees the
// register. cfg_wr_en writes the entry count; the user must use it only
// while the block is idle, which the block does not enforce.
// Reset clears the sequencer, the output valid and the entry count; the
// table is not cleared and must be written before it is queried.
module nearest_box_table_search #(
  parameter int MAX_ENTRIES = nbts_pkg::DEF_MAX_ENTRIES,
  parameter int NUM_AXES    = nbts_pkg::DEF_NUM_AXES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [nbts_pkg::CNT_BITS-1:0]      cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [nbts_pkg::IDX_BITS-1:0]      in_entry_index,
  input  logic [2:0]                         in_axis_index,
  input  nbts_pkg::coord_t                   in_low_bound,
  input  nbts_pkg::coord_t                   in_high_bound,
  input  logic [nbts_pkg::ID_BITS-1:0]       in_result_id,
  input  nbts_pkg::coord_t                   in_temperature,
  input  nbts_pkg::coord_t                   in_humidity,
  input  nbts_pkg::coord_t                   in_continentalness,
  input  nbts_pkg::coord_t                   in_erosion,
  input  nbts_pkg::coord_t                   in_depth_coord,
  input  nbts_pkg::coord_t                   in_weirdness,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nbts_pkg::ID_BITS-1:0]       out_best_id,
  output logic [nbts_pkg::IDX_BITS-1:0]      out_best_index,
  output logic [nbts_pkg::FIT_BITS-1:0]      out_best_fitness,
  output logic                               out_empty_error
);
  import nbts_pkg::*;

  localparam int ROW   = NUM_AXES + 1;
  localparam int SW    = $clog2(ROW);
  localparam int DEPTH = MAX_ENTRIES * ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int WA_BITS = IDX_BITS + 4;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t                         state_r;
  logic [CNT_BITS-1:0]            count_r;
  logic [AW-1:0]                  addr_r;
  logic [SW-1:0]                  slot_r;
  logic [IDX_BITS-1:0]            entry_r, last_entry_r;
  logic                           empty_r;
  coord_t [SAMPLE_FIELDS-1:0]     sample_r;
  logic                           out_valid_r;
  logic [ID_BITS-1:0]             out_best_id_r;
  logic [IDX_BITS-1:0]            out_best_index_r;
  logic [FIT_BITS-1:0]            out_best_fitness_r;
  logic                           out_empty_error_r;

  logic                           in_xfer;
  logic                           wr_en;
  logic [WA_BITS-1:0]             wr_addr_wide;
  coord_t                         wr_hi;
  logic                           slot_last;
  scan_tag_t                      issue_tag;
  coord_t                         lo_rd, hi_rd;
  logic [ID_BITS-1:0]             id_rd;
  logic                           fit_busy;
  logic [FIT_BITS-1:0]            best_fit;
  logic [IDX_BITS-1:0]            best_idx;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;

  // Table write: drop entries beyond the table and axes beyond the offset
  assign wr_en = in_xfer && (in_action == ACT_WRITE) &&
                 (32'(in_entry_index) < 32'(MAX_ENTRIES)) &&
                 (32'(in_axis_index) <= 32'(NUM_AXES));
  assign wr_addr_wide = ({4'b0, in_entry_index} * WA_BITS'(ROW)) +
                        WA_BITS'(in_axis_index);
  // Offset slot holds a zero-width range at the offset
  assign wr_hi = (32'(in_axis_index) == 32'(NUM_AXES)) ? in_low_bound : in_high_bound;

  assign slot_last = (32'(slot_r) == 32'(NUM_AXES));

  always_comb begin
    issue_tag       = '0;
    issue_tag.valid = (state_r == S_SCAN);
    issue_tag.first = (slot_r == '0);
    issue_tag.last  = slot_last;
    issue_tag.entry = entry_r;
  end

  nbts_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NUM_AXES    (NUM_AXES)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (AW'(wr_addr_wide)),
    .wr_entry (EW'(in_entry_index)),
    .wr_lo    (in_low_bound),
    .wr_hi    (wr_hi),
    .wr_id    (in_result_id),
    .rd_addr  (addr_r),
    .id_addr  (EW'(best_idx)),
    .lo_rd_r  (lo_rd),
    .hi_rd_r  (hi_rd),
    .id_rd_r  (id_rd)
  );

  nbts_fit_unit #(
    .NUM_AXES (NUM_AXES)
  ) u_fit (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue_tag  (issue_tag),
    .sample     (sample_r),
    .lo_rd      (lo_rd),
    .hi_rd      (hi_rd),
    .busy       (fit_busy),
    .best_fit_r (best_fit),
    .best_idx_r (best_idx)
  );

  // Entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      slot_r      <= '0;
      entry_r     <= '0;
    end else begin
      // drop the result once transferred; the done state reloads it itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_action == ACT_QUERY) begin
            sample_r <= {in_weirdness, in_depth_coord, in_erosion,
                         in_continentalness, in_humidity, in_temperature};
            addr_r   <= '0;
            slot_r   <= '0;
            entry_r  <= '0;
            if (count_r == '0) begin
              empty_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              empty_r      <= 1'b0;
              last_entry_r <= IDX_BITS'((32'(count_r) > 32'(MAX_ENTRIES) ?
                                         32'(MAX_ENTRIES) : 32'(count_r)) - 32'd1);
              state_r      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          addr_r <= addr_r + AW'(1);
          if (slot_last) begin
            slot_r  <= '0;
            entry_r <= entry_r + IDX_BITS'(1);
            if (entry_r == last_entry_r) begin
              state_r <= S_DRAIN;
            end
          end else begin
            slot_r <= slot_r + SW'(1);
          end
        end
        S_DRAIN: begin
          // id read of the final winner issues at this edge
          if (!fit_busy) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r       <= 1'b1;
            out_empty_error_r <= empty_r;
            if (empty_r) begin
              out_best_id_r      <= '0;
              out_best_index_r   <= '0;
              out_best_fitness_r <= '0;
            end else begin
              out_best_id_r      <= id_rd;
              out_best_index_r   <= best_idx;
              out_best_fitness_r <= best_fit;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_best_id      = out_best_id_r;
  assign out_best_index   = out_best_index_r;
  assign out_best_fitness = out_best_fitness_r;
  assign out_empty_error  = out_empty_error_r;

endmodule

### hdl/nbts_table.sv
`timescale 1ns / 1ps
module nbts_table #(
  parameter int MAX_ENTRIES = nbts_pkg::DEF_MAX_ENTRIES,
  parameter int NUM_AXES    = nbts_pkg::DEF_NUM_AXES
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(MAX_ENTRIES*(NUM_AXES+1))-1:0] wr_addr,
  input  logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_entry,
  input  nbts_pkg::coord_t                       wr_lo,
  input  nbts_pkg::coord_t                       wr_hi,
  input  logic [nbts_pkg::ID_BITS-1:0]           wr_id,
  input  logic [$clog2(MAX_ENTRIES*(NUM_AXES+1))-1:0] rd_addr,
  input  logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] id_addr,
  output nbts_pkg::coord_t                       lo_rd_r,
  output nbts_pkg::coord_t                       hi_rd_r,
  output logic [nbts_pkg::ID_BITS-1:0]           id_rd_r
);
  import nbts_pkg::*;

  localparam int DEPTH = MAX_ENTRIES * (NUM_AXES + 1);

  // Each entry takes NUM_AXES range slots followed by one offset slot
  coord_t               lo_mem [DEPTH];
  coord_t               hi_mem [DEPTH];
  logic [ID_BITS-1:0]   id_mem [MAX_ENTRIES];

  // Range and offset store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_mem[wr_addr] <= wr_lo;
      hi_mem[wr_addr] <= wr_hi;
    end
    lo_rd_r <= lo_mem[rd_addr];
    hi_rd_r <= hi_mem[rd_addr];
  end

  // Id store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_entry] <= wr_id;
    end
    id_rd_r <= id_mem[id_addr];
  end

endmodule

### hdl/nbts_fit_unit.sv
`timescale 1ns / 1ps
module nbts_fit_unit #(
  parameter int NUM_AXES = nbts_pkg::DEF_NUM_AXES
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  nbts_pkg::scan_tag_t                             issue_tag,
  input  nbts_pkg::coord_t [nbts_pkg::SAMPLE_FIELDS-1:0]  sample,
  input  nbts_pkg::coord_t                                lo_rd,
  input  nbts_pkg::coord_t                                hi_rd,
  output logic                                            busy,
  output logic [nbts_pkg::FIT_BITS-1:0]                   best_fit_r,
  output logic [nbts_pkg::IDX_BITS-1:0]                   best_idx_r
);
  import nbts_pkg::*;

  localparam int ROW      = NUM_AXES + 1;
  localparam int SW       = $clog2(ROW);
  localparam int SUM_BITS = FIT_BITS + 1;

  scan_tag_t            tag_b_r, tag_c_r, tag_d_r;
  logic [SW-1:0]        slot_b_r;
  logic [SW-1:0]        slot_nxt;
  coord_t               coord;
  logic signed [CW:0]   diff_lo, diff_hi;
  logic [CW-1:0]        d_nxt, d_r;
  logic [2*CW-1:0]      sq_r;
  logic [FIT_BITS-1:0]  acc_r, acc_nxt;
  logic [SUM_BITS-1:0]  sum;

  // Slot counter of the read in flight; restarts at each entry
  always_comb begin
    if (issue_tag.first) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_b_r + SW'(1);
    end
  end

  // Advance the tags along with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r  <= '0;
      tag_c_r  <= '0;
      tag_d_r  <= '0;
      slot_b_r <= '0;
    end else begin
      tag_b_r <= issue_tag;
      tag_c_r <= tag_b_r;
      tag_d_r <= tag_c_r;
      if (issue_tag.valid) begin
        slot_b_r <= slot_nxt;
      end
    end
  end

  assign busy = tag_b_r.valid | tag_c_r.valid | tag_d_r.valid;

  // Pick the sample coordinate; offset slot and missing axes measure from zero
  always_comb begin
    coord = '0;
    if (32'(slot_b_r) < 32'(NUM_AXES) && 32'(slot_b_r) < 32'(SAMPLE_FIELDS)) begin
      coord = sample[3'(slot_b_r)];
    end
  end

  // Distance outside the range
  assign diff_lo = {lo_rd[CW-1], lo_rd} - {coord[CW-1], coord};
  assign diff_hi = {coord[CW-1], coord} - {hi_rd[CW-1], hi_rd};

  always_comb begin
    if (coord < lo_rd) begin
      d_nxt = diff_lo[CW-1:0];
    end else if (coord > hi_rd) begin
      d_nxt = diff_hi[CW-1:0];
    end else begin
      d_nxt = '0;
    end
  end

  // Shared squarer
  always_ff @(posedge clk) begin
    d_r  <= d_nxt;
    sq_r <= {{CW{1'b0}}, d_r} * {{CW{1'b0}}, d_r};
  end

  // Saturating accumulate of the entry's terms
  always_comb begin
    if (tag_d_r.first) begin
      sum = SUM_BITS'(sq_r);
    end else begin
      sum = {1'b0, acc_r} + SUM_BITS'(sq_r);
    end
    if (sum[SUM_BITS-1]) begin
      acc_nxt = '1;
    end else begin
      acc_nxt = sum[FIT_BITS-1:0];
    end
  end

  // Keep the best entry; a tie goes to the later one
  always_ff @(posedge clk) begin
    if (tag_d_r.valid) begin
      acc_r <= acc_nxt;
      if (tag_d_r.last &&
          (tag_d_r.entry == '0 || acc_nxt <= best_fit_r)) begin
        best_fit_r <= acc_nxt;
        best_idx_r <= tag_d_r.entry;
      end
    end
  end

endmodule

### hdl/nbts_checker.sv
`timescale 1ns / 1ps
module nbts_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_action,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [nbts_pkg::ID_BITS-1:0]       out_best_id,
  input logic [nbts_pkg::IDX_BITS-1:0]      out_best_index,
  input logic [nbts_pkg::FIT_BITS-1:0]      out_best_fitness,
  input logic                               out_empty_error
);
  import nbts_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_id) &&
      $stable(out_best_index) && $stable(out_best_fitness) && $stable(out_empty_error))
    else $error("stalled result changed");

  // An empty-table result carries no answer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_error |->
      out_best_id == '0 && out_best_index == '0 && out_best_fitness == '0)
    else $error("empty result with non-zero fields");

  // A query transfer closes the input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_QUERY |=> !in_ready)
    else $error("input open during a query");

  // A write transfer leaves the input open
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_WRITE |=> in_ready)
    else $error("write stalled the input");

  // No result straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_box_table_search nbts_checker u_nbts_checker (.*);
